// File: rtl/sobf_pkg.sv
package sobf_pkg;

  typedef logic [31:0] word_t;
  typedef logic [63:0] dword_t;

  // Magnitude width of a sine or scaled sample before the sign is applied.
  localparam int MAG_W = 15;

  // Half pi in Q30, the angle of a full quarter wave.
  localparam word_t HALF_PI_Q30 = 32'd1686629713;

  // Taylor terms after the first: divisors (2k)(2k+1) and floor(2^32 / divisor).
  localparam int TERMS = 5;
  localparam logic [6:0] DIVISOR [TERMS] = '{7'd6, 7'd20, 7'd42, 7'd72, 7'd110};
  localparam word_t RECIP [TERMS] = '{
    32'd715827882, 32'd214748364, 32'd102261126, 32'd59652323, 32'd39045157
  };

  localparam logic [MAG_W-1:0] SINE_MAX = 15'd32767;
  localparam logic [15:0] AMP_ONE = 16'd32768;

  // Block modes.
  localparam logic [1:0] MODE_SILENT   = 2'd0;
  localparam logic [1:0] MODE_STEADY   = 2'd1;
  localparam logic [1:0] MODE_FADE_IN  = 2'd2;
  localparam logic [1:0] MODE_FADE_OUT = 2'd3;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [1:0] REG_AMPLITUDE  = 2'd1;
  localparam logic [1:0] REG_FRAMES     = 2'd2;

  localparam word_t       PHASE_STEP_RST = 32'd39370534;
  localparam logic [15:0] AMPLITUDE_RST  = 16'd16384;
  localparam logic [12:0] FRAMES_RST     = 13'd256;

endpackage

// File: rtl/sine_oscillator_with_block_fade_top.sv
// Sine oscillator with block-wise fade in and fade out.
//
// Each word taken on the s_axis channel carries the on/off request and yields
// exactly one word on the m_axis channel: a signed 16-bit sample, with tlast
// marking the last sample of a block. The request is only looked at on the
// first sample of a block, where it selects steady tone, fade in, fade out or
// silence for the whole block.
// Registers are written through the cfg channel, which is always ready; they
// should only be changed while no word is in flight.
// The sine is computed per sample by one shared 32x32 multiplier under a small
// sequencer: angle, square, five Taylor terms (each a multiply, a reciprocal
// multiply and a correction), rounding and gain. A silent sample skips the
// sequence and goes straight to the output register; a fade sample adds a
// one-bit-per-cycle divide by the block length after the gain.
// s_axis_tready is high only while the sequencer is idle, so a new word is
// not taken until the previous one has left the sequencer.
// A finished word waits in the output register; if the receiver stalls, the
// next word is accepted and computed but held until the register frees up.
// Reset is synchronous: registers return to their defaults, the phase to
// zero, and the first block fades in if its request is on, else is silent.
module sine_oscillator_with_block_fade_top #(
  parameter int MAX_FRAMES      = 4096,
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] wave_on, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample
  output logic        m_axis_tlast,   // block_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sobf_pkg::*;

  localparam int FW = $clog2(MAX_FRAMES);
  localparam int LW = FW + 1;
  localparam int RW = SINE_TABLE_BITS - 2;
  localparam int QW = RW + 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ANG   = 4'd1;
  localparam logic [3:0] ST_SQR   = 4'd2;
  localparam logic [3:0] ST_A2    = 4'd3;
  localparam logic [3:0] ST_RCP   = 4'd4;
  localparam logic [3:0] ST_BACK  = 4'd5;
  localparam logic [3:0] ST_FIX   = 4'd6;
  localparam logic [3:0] ST_ROUND = 4'd7;
  localparam logic [3:0] ST_GAIN  = 4'd8;
  localparam logic [3:0] ST_FADE  = 4'd9;
  localparam logic [3:0] ST_WAIT  = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  // Configuration registers.
  word_t       phase_step;
  logic [15:0] amplitude;
  logic [12:0] frames_per_block;

  // Oscillator state.
  logic [PHASE_BITS-1:0] phase_acc;
  logic [FW-1:0]         frame_index;
  logic [1:0]            block_mode;
  logic                  was_on;
  logic                  faded_out;

  // Sequencer.
  logic [3:0]       st;
  logic [QW-1:0]    q_arg;
  logic             neg;
  logic [1:0]       mode_run;
  logic [LW-1:0]    num;
  logic [LW-1:0]    len_run;
  logic             end_run;
  word_t            a2;
  word_t            t;
  word_t            s;
  word_t            x;
  word_t            qe;
  logic [2:0]       k;
  logic [MAG_W-1:0] res;
  dword_t           prod;

  // Combinational helpers.
  logic [LW-1:0]          len;
  logic [LW-1:0]          idx;
  logic                   ending;
  logic [1:0]             mode_new;
  logic                   accept;
  logic [SINE_TABLE_BITS-1:0] addr;
  logic [RW-1:0]          r_off;
  logic [QW-1:0]          q_new;
  logic [15:0]            amp_sat;
  word_t                  mul_a;
  word_t                  mul_b;
  word_t                  t_new;
  word_t                  s_new;
  dword_t                 rsum;
  logic [16:0]            v_wide;
  logic [MAG_W-1:0]       v;
  word_t                  gsum;
  logic [MAG_W-1:0]       m;
  logic                   div_start;
  logic                   div_done;
  logic [MAG_W-1:0]       div_q;
  logic [15:0]            mag16;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (st == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step       <= PHASE_STEP_RST;
      amplitude        <= AMPLITUDE_RST;
      frames_per_block <= FRAMES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PHASE_STEP: phase_step <= cfg_data;
        REG_AMPLITUDE:  amplitude <= cfg_data[15:0];
        REG_FRAMES:     frames_per_block <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign amp_sat = (amplitude > AMP_ONE) ? AMP_ONE : amplitude;

  always_comb begin
    if (frames_per_block == 13'd0) begin
      len = LW'(1);
    end else if ({19'd0, frames_per_block} > 32'(MAX_FRAMES)) begin
      len = LW'(MAX_FRAMES);
    end else begin
      len = LW'(frames_per_block);
    end
  end

  assign idx    = ({1'b0, frame_index} > len) ? len : {1'b0, frame_index};
  assign ending = ({1'b0, frame_index} + LW'(1)) >= len;

  always_comb begin
    mode_new = block_mode;
    if (frame_index == '0) begin
      if (s_axis_tdata[0]) begin
        mode_new = was_on ? MODE_STEADY : MODE_FADE_IN;
      end else if (!faded_out) begin
        mode_new = MODE_FADE_OUT;
      end else begin
        mode_new = MODE_SILENT;
      end
    end
  end

  // Full-cycle table address folded onto the quarter wave.
  assign addr  = phase_acc[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign r_off = addr[RW-1:0];
  assign q_new = addr[RW] ? ((QW'(1) << RW) - {1'b0, r_off}) : {1'b0, r_off};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc   <= '0;
      frame_index <= '0;
      block_mode  <= MODE_SILENT;
      was_on      <= 1'b0;
      faded_out   <= 1'b1;
    end else if (accept) begin
      block_mode  <= mode_new;
      frame_index <= ending ? '0 : frame_index + FW'(1);
      if (frame_index == '0) begin
        if (s_axis_tdata[0]) begin
          was_on    <= 1'b1;
          faded_out <= 1'b0;
        end else if (!faded_out) begin
          was_on    <= 1'b0;
          faded_out <= 1'b1;
        end
      end
      if (mode_new != MODE_SILENT) begin
        phase_acc <= phase_acc + PHASE_BITS'(phase_step);
      end
    end
  end

  // Term correction: the reciprocal estimate is at most one below the quotient.
  always_comb begin
    t_new = ((x - prod[31:0]) >= {25'd0, DIVISOR[k]}) ? qe + 32'd1 : qe;
    s_new = k[0] ? s + t_new : s - t_new;
  end

  always_comb begin
    rsum   = prod + 64'h2000_0000;
    v_wide = rsum[46:30];
    v      = (v_wide > {2'b0, SINE_MAX}) ? SINE_MAX : v_wide[MAG_W-1:0];
    gsum   = prod[31:0] + 32'd16384;
    m      = gsum[29:15];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st)
      ST_ANG: begin
        mul_a = 32'(q_arg);
        mul_b = HALF_PI_Q30;
      end
      ST_SQR: begin
        mul_a = prod[RW +: 32];
        mul_b = prod[RW +: 32];
      end
      ST_A2: begin
        mul_a = t;
        mul_b = prod[61:30];
      end
      ST_RCP: begin
        mul_a = prod[61:30];
        mul_b = RECIP[k];
      end
      ST_BACK: begin
        mul_a = prod[63:32];
        mul_b = {25'd0, DIVISOR[k]};
      end
      ST_FIX: begin
        if (k == 3'(TERMS - 1)) begin
          mul_a = s_new;
          mul_b = {17'd0, SINE_MAX};
        end else begin
          mul_a = t_new;
          mul_b = a2;
        end
      end
      ST_ROUND: begin
        mul_a = {17'd0, v};
        mul_b = {16'd0, amp_sat};
      end
      ST_GAIN: begin
        mul_a = {17'd0, m};
        mul_b = 32'(num);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {32'd0, mul_a} * {32'd0, mul_b};
  end

  assign div_start = (st == ST_FADE);

  sobf_div #(
    .DEN_W (LW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[MAG_W+LW-1:0]),
    .divisor  (len_run),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (accept) begin
            st <= (mode_new == MODE_SILENT) ? ST_DONE : ST_ANG;
          end
        end
        ST_ANG:  st <= ST_SQR;
        ST_SQR:  st <= ST_A2;
        ST_A2:   st <= ST_RCP;
        ST_RCP:  st <= ST_BACK;
        ST_BACK: st <= ST_FIX;
        ST_FIX:  st <= (k == 3'(TERMS - 1)) ? ST_ROUND : ST_RCP;
        ST_ROUND: st <= ST_GAIN;
        ST_GAIN: st <= (mode_run == MODE_STEADY) ? ST_DONE : ST_FADE;
        ST_FADE: st <= ST_WAIT;
        ST_WAIT: begin
          if (div_done) begin
            st <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: begin
        q_arg    <= q_new;
        neg      <= addr[SINE_TABLE_BITS-1];
        mode_run <= mode_new;
        num      <= (mode_new == MODE_FADE_IN) ? idx : len - idx;
        len_run  <= len;
        end_run  <= ending;
        res      <= '0;
        k        <= '0;
      end
      ST_SQR: begin
        s <= prod[RW +: 32];
        t <= prod[RW +: 32];
      end
      ST_A2:   a2 <= prod[61:30];
      ST_RCP:  x <= prod[61:30];
      ST_BACK: qe <= prod[63:32];
      ST_FIX: begin
        s <= s_new;
        t <= t_new;
        k <= k + 3'd1;
      end
      ST_GAIN: res <= m;
      ST_WAIT: begin
        if (div_done) begin
          res <= div_q;
        end
      end
      default: ;
    endcase
  end

  assign mag16 = {1'b0, res};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (st == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= neg ? 16'(16'd0 - mag16) : mag16;
      m_axis_tlast <= end_run;
    end
  end

endmodule

// File: rtl/sobf_div.sv
module sobf_div #(
  parameter int DEN_W = 13
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [sobf_pkg::MAG_W+DEN_W-1:0]    dividend,
  input  logic [DEN_W-1:0]                    divisor,
  output logic                                done,
  output logic [sobf_pkg::MAG_W-1:0]          quotient
);
  import sobf_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  // The quotient is known to fit in MAG_W bits, so the top of the dividend
  // is already a valid partial remainder and only MAG_W steps are needed.
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [MAG_W-1:0] low;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial    = {rem, low[MAG_W-1]};
  assign ge       = trial >= {1'b0, den};
  assign quotient = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MAG_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[MAG_W +: DEN_W];
      low <= dividend[MAG_W-1:0];
      den <= divisor;
    end else if (busy) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      low <= {low[MAG_W-2:0], ge};
    end
  end

endmodule
